FILE: design/sbfd_pkg.sv
package sbfd_pkg;

	// Frame layout.
	localparam int FRAME_LEN    = 25;
	localparam int STORED_LEN   = 24;
	localparam int NUM_CHANNELS = 16;
	localparam int CHAN_W       = 11;
	localparam int PAYLOAD_BYTES = 22;
	localparam int PAYLOAD_W    = PAYLOAD_BYTES * 8;

	// Framing bytes and flag bits.
	localparam logic [7:0] START_BYTE   = 8'h0F;
	localparam logic [7:0] END_BYTE     = 8'h00;
	localparam int         FAILSAFE_POS = 3;
	localparam int         LOST_POS     = 2;
	localparam int         FLAG_BYTE    = 23;

	// One checked frame as handed from the front to the back.
	typedef struct packed {
		logic [PAYLOAD_W-1:0] chan_bits;
		logic                 failsafe;
		logic                 lost;
	} frame_t;

	// Status of the frame queue.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: design/sbus_frame_decoder.sv
// SBUS frame decoder: one byte taken per cycle unless full; sixteen channel results per good frame.
// The first result of a frame passes through the frame queue and the result register after the
// transfer of its 25th byte; the other fifteen follow one per cycle while results are popped.
// Throughput: one byte per cycle; full rises only on a closing byte when both frame slots hold
// frames the result side has not yet drained (sixteen pops per frame).
// Reset clears byte counter, queue state, channel counter and result valid; stored data keeps junk.
module sbus_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_value,
	output logic        failsafe_flag,
	output logic        lost_flag,
	output logic        last_of_frame
);
	import sbfd_pkg::*;

	qstat_t qstat;
	frame_t enq_frame;
	frame_t head_frame;
	logic   enq;
	logic   deq;

	// Byte counting and frame check.
	sbfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.qstat     (qstat),
		.enq       (enq),
		.enq_frame (enq_frame)
	);

	// Two-frame queue between the byte side and the result side.
	sbfd_frame_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.enq        (enq),
		.enq_frame  (enq_frame),
		.deq        (deq),
		.qstat      (qstat),
		.head_frame (head_frame)
	);

	// Channel unpacking and result register.
	sbfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.head_frame    (head_frame),
		.deq           (deq),
		.empty         (empty),
		.pop           (pop),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.failsafe_flag (failsafe_flag),
		.lost_flag     (lost_flag),
		.last_of_frame (last_of_frame)
	);

endmodule

FILE: design/sbfd_front.sv
module sbfd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      rx_byte,
	input  sbfd_pkg::qstat_t qstat,
	output logic            enq,
	output sbfd_pkg::frame_t enq_frame
);
	import sbfd_pkg::*;

	logic [4:0] pos_q;
	logic [7:0] buf_q [STORED_LEN];
	logic       accept;
	logic       at_end;

	// The frame can only stall on its closing byte, when both queue slots are taken.
	assign at_end = (pos_q >= 5'(STORED_LEN));
	assign full   = at_end && qstat.full;
	assign accept = push && !full;

	// Byte counter: restarts after every 25th byte, good frame or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (at_end) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	// Frame store, written one byte per transfer.
	always_ff @(posedge clk) begin
		if (accept && !at_end) begin
			buf_q[pos_q] <= rx_byte;
		end
	end

	// A frame is queued when its start and end bytes check out.
	assign enq = accept && at_end && (buf_q[0] == START_BYTE) && (rx_byte == END_BYTE);

	// Payload bytes 1 to 22 form one bit stream, byte 1 at the bottom.
	always_comb begin
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			enq_frame.chan_bits[i*8 +: 8] = buf_q[i+1];
		end
		enq_frame.failsafe = buf_q[FLAG_BYTE][FAILSAFE_POS];
		enq_frame.lost     = buf_q[FLAG_BYTE][LOST_POS];
	end

endmodule

FILE: design/sbfd_frame_queue.sv
module sbfd_frame_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             enq,
	input  sbfd_pkg::frame_t enq_frame,
	input  logic             deq,
	output sbfd_pkg::qstat_t qstat,
	output sbfd_pkg::frame_t head_frame
);
	import sbfd_pkg::*;

	frame_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign head_frame  = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Frame slots.
	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= enq_frame;
		end
	end

endmodule

FILE: design/sbfd_back.sv
module sbfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sbfd_pkg::qstat_t qstat,
	input  sbfd_pkg::frame_t head_frame,
	output logic             deq,
	output logic             empty,
	input  logic             pop,
	output logic [3:0]       channel_index,
	output logic [10:0]      channel_value,
	output logic             failsafe_flag,
	output logic             lost_flag,
	output logic             last_of_frame
);
	import sbfd_pkg::*;

	logic [3:0]        ch_q;
	logic              out_valid_q;
	logic              advance;
	logic              issue;
	logic              last_ch;
	logic [CHAN_W-1:0] chans [NUM_CHANNELS];

	// Each channel is a fixed 11-bit slice of the payload stream.
	always_comb begin
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			chans[k] = head_frame.chan_bits[k*CHAN_W +: CHAN_W];
		end
	end

	// The output register takes a new result when it is free or being emptied.
	assign advance = !out_valid_q || pop;
	assign issue   = advance && !qstat.empty;
	assign last_ch = (ch_q == 4'(NUM_CHANNELS - 1));
	assign deq     = issue && last_ch;
	assign empty   = !out_valid_q;

	// Channel counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				ch_q <= ch_q + 4'd1;
			end
			if (advance) begin
				out_valid_q <= !qstat.empty;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (issue) begin
			channel_index <= ch_q;
			channel_value <= chans[ch_q];
			failsafe_flag <= head_frame.failsafe;
			lost_flag     <= head_frame.lost;
			last_of_frame <= last_ch;
		end
	end

endmodule
